@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority ready queue.
// Used by spq_ram and sorted_priority_ready_queue; depends on nothing else.
`default_nettype none

package spq_pkg;

    localparam int ID_BITS  = 8;
    localparam int KEY_BITS = 16;
    localparam int OCC_BITS = 5;

    // Operation codes carried in the command beat.
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    // Completion codes reported in the result beat.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_TAIL
    } t_state;

    typedef struct packed {
        t_mode                 mode;
        logic [ID_BITS-1:0]    proc_id;
        logic [KEY_BITS-1:0]   prio_key;
    } t_in_beat;

    typedef struct packed {
        t_status               status;
        logic [ID_BITS-1:0]    popped_id;
        logic [KEY_BITS-1:0]   found_key;
        logic                  found;
        logic [OCC_BITS-1:0]   occupancy;
        logic [ID_BITS-1:0]    next_id;
    } t_out_beat;

    // One queue slot as held in the entry memory.
    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [KEY_BITS-1:0]   key;
    } t_entry;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_priority_ready_queue.sv @@
// Top level of the sorted priority ready queue: command sequencer around the
// entry memory. Depends on spq_pkg and spq_ram.
//
// Usage:
//   A command beat (mode, proc_id, prio_key on i_cmd) is taken at a rising
//   edge with start high and busy low. busy stays high while the command
//   walks the entry memory. Exactly one result beat follows on o_result,
//   marked by o_strobe for a single cycle; the receiver cannot stall it.
//   A new command may be accepted in the same cycle as the strobe.
//   Entries are kept sorted by key, largest at slot 0, in a single memory
//   with one read and one write port and registered read data.
//   How long a command takes depends on the walk over the memory port, one
//   slot per cycle: a push walks from the tail down to its insertion slot, a
//   remove or query reads every held entry from the head, a pop walks nothing
//   and an error (full, empty) touches no memory. Push, pop and a remove that
//   finds its id end with a read of the tail slot that refreshes the cached
//   next id, unless the queue is then empty.
//   Reset (synchronous, active low) empties the queue; memory is not cleared.
`default_nettype none

module sorted_priority_ready_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire spq_pkg::t_in_beat    i_cmd,
    output      logic                 busy,
    output      logic                 o_strobe,
    output      spq_pkg::t_out_beat   o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::t_state                  r_state, n_state;
    spq_pkg::t_mode                   r_mode, n_mode;
    logic [spq_pkg::ID_BITS-1:0]      r_id, n_id;
    logic [spq_pkg::KEY_BITS-1:0]     r_key, n_key;
    logic [CW-1:0]                    r_fill, n_fill;
    logic [CW-1:0]                    r_idx, n_idx;
    logic [AW-1:0]                    r_didx, n_didx;
    logic                             r_pend, n_pend;
    logic                             r_hit, n_hit;
    logic [spq_pkg::ID_BITS-1:0]      r_tail_id, n_tail_id;
    spq_pkg::t_status                 r_status, n_status;
    logic [spq_pkg::ID_BITS-1:0]      r_popped, n_popped;
    logic [spq_pkg::KEY_BITS-1:0]     r_fkey, n_fkey;
    logic                             r_found, n_found;
    logic                             r_done, n_done;

    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    spq_pkg::t_entry                  mem_wdata;
    logic [AW-1:0]                    mem_raddr;
    spq_pkg::t_entry                  mem_rdata;

    logic [CW-1:0]                    idx_m1;
    logic [CW-1:0]                    idx_m2;
    logic [CW-1:0]                    fill_m1;
    logic                             is_full;
    logic                             is_empty;
    logic                             scan_end;
    logic                             shift_up;
    spq_pkg::t_entry                  new_entry;

    spq_ram #(
        .DEPTH   (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Helper terms for the next-state and datapath logic.
    assign idx_m1    = r_idx - CW'(1);
    assign idx_m2    = r_idx - CW'(2);
    assign fill_m1   = r_fill - CW'(1);
    assign is_full   = (r_fill == CW'(DEPTH));
    assign is_empty  = (r_fill == '0);
    assign scan_end  = (r_idx == r_fill) && !r_pend;
    assign shift_up  = (mem_rdata.key <= r_key);
    assign new_entry = '{id: r_id, key: r_key};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_cmd.mode)
                        spq_pkg::MODE_PUSH: begin
                            n_state = is_full ? spq_pkg::ST_IDLE : spq_pkg::ST_PUSH;
                        end
                        spq_pkg::MODE_POP: begin
                            n_state = is_empty ? spq_pkg::ST_IDLE : spq_pkg::ST_TAIL;
                        end
                        default: begin
                            n_state = is_empty ? spq_pkg::ST_IDLE : spq_pkg::ST_SCAN;
                        end
                    endcase
                end
            end
            spq_pkg::ST_PUSH: begin
                if (!r_pend) begin
                    if (r_idx == '0) begin
                        n_state = spq_pkg::ST_TAIL;
                    end
                end else if (!shift_up) begin
                    n_state = spq_pkg::ST_TAIL;
                end
            end
            spq_pkg::ST_SCAN: begin
                if (scan_end) begin
                    if (r_hit && r_mode == spq_pkg::MODE_REMOVE) begin
                        n_state = spq_pkg::ST_TAIL;
                    end else begin
                        n_state = spq_pkg::ST_IDLE;
                    end
                end
            end
            spq_pkg::ST_TAIL: begin
                if (is_empty || r_pend) begin
                    n_state = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and result registers.
    always_comb begin
        n_mode    = r_mode;
        n_id      = r_id;
        n_key     = r_key;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_didx    = r_didx;
        n_pend    = r_pend;
        n_hit     = r_hit;
        n_tail_id = r_tail_id;
        n_status  = r_status;
        n_popped  = r_popped;
        n_fkey    = r_fkey;
        n_found   = r_found;
        n_done    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = new_entry;
        mem_raddr = '0;

        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                if (start) begin
                    n_mode   = i_cmd.mode;
                    n_id     = i_cmd.proc_id;
                    n_key    = i_cmd.prio_key;
                    n_status = spq_pkg::STAT_OK;
                    n_popped = '0;
                    n_fkey   = '0;
                    n_found  = 1'b0;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                    n_idx    = (i_cmd.mode == spq_pkg::MODE_PUSH) ? r_fill : '0;
                    unique case (i_cmd.mode)
                        spq_pkg::MODE_PUSH: begin
                            if (is_full) begin
                                n_status = spq_pkg::STAT_FULL;
                                n_done   = 1'b1;
                            end
                        end
                        spq_pkg::MODE_POP: begin
                            if (is_empty) begin
                                n_status = spq_pkg::STAT_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                // The tail id is kept current after every command.
                                n_popped = r_tail_id;
                                n_fill   = fill_m1;
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                n_status = spq_pkg::STAT_EMPTY;
                                n_done   = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // Walk from the tail toward the head, moving each entry with a key
            // not above the new one up by one slot, then drop the new entry in.
            spq_pkg::ST_PUSH: begin
                if (!r_pend) begin
                    if (r_idx == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = new_entry;
                        n_fill    = r_fill + CW'(1);
                    end else begin
                        mem_raddr = idx_m1[AW-1:0];
                        n_pend    = 1'b1;
                    end
                end else if (shift_up) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx[AW-1:0];
                    mem_wdata = mem_rdata;
                    n_idx     = idx_m1;
                    if (idx_m1 == '0) begin
                        n_pend = 1'b0;
                    end else begin
                        mem_raddr = idx_m2[AW-1:0];
                        n_pend    = 1'b1;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx[AW-1:0];
                    mem_wdata = new_entry;
                    n_fill    = r_fill + CW'(1);
                    n_pend    = 1'b0;
                end
            end

            // Read every held slot from the head. The first id match is
            // recorded; on a remove, every later entry moves down one slot.
            // Only a query reports the key of the match.
            spq_pkg::ST_SCAN: begin
                if (r_pend) begin
                    if (r_hit) begin
                        if (r_mode == spq_pkg::MODE_REMOVE) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_didx - AW'(1);
                            mem_wdata = mem_rdata;
                        end
                    end else if (mem_rdata.id == r_id) begin
                        n_hit = 1'b1;
                        if (r_mode == spq_pkg::MODE_QUERY) begin
                            n_fkey = mem_rdata.key;
                        end
                    end
                end
                if (r_idx != r_fill) begin
                    mem_raddr = r_idx[AW-1:0];
                    n_didx    = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (scan_end) begin
                    if (!r_hit) begin
                        n_status = spq_pkg::STAT_NOT_FOUND;
                        n_done   = 1'b1;
                    end else if (r_mode == spq_pkg::MODE_QUERY) begin
                        n_found = 1'b1;
                        n_done  = 1'b1;
                    end else begin
                        n_fill = fill_m1;
                    end
                end
            end

            // Refresh the cached id of the tail slot unless the queue is empty, then finish.
            spq_pkg::ST_TAIL: begin
                if (is_empty) begin
                    n_done = 1'b1;
                end else if (!r_pend) begin
                    mem_raddr = fill_m1[AW-1:0];
                    n_pend    = 1'b1;
                end else begin
                    n_tail_id = mem_rdata.id;
                    n_pend    = 1'b0;
                    n_done    = 1'b1;
                end
            end

            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spq_pkg::ST_IDLE;
            r_fill    <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_done    <= 1'b0;
            r_tail_id <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_pend    <= n_pend;
            r_hit     <= n_hit;
            r_done    <= n_done;
            r_tail_id <= n_tail_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_id     <= n_id;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_didx   <= n_didx;
        r_status <= n_status;
        r_popped <= n_popped;
        r_fkey   <= n_fkey;
        r_found  <= n_found;
    end

    // Result beat and handshake outputs.
    assign busy     = (r_state != spq_pkg::ST_IDLE);
    assign o_strobe = r_done;

    always_comb begin
        o_result.status    = r_status;
        o_result.popped_id = r_popped;
        o_result.found_key = r_fkey;
        o_result.found     = r_found;
        o_result.occupancy = spq_pkg::OCC_BITS'(r_fill);
        o_result.next_id   = is_empty ? '0 : r_tail_id;
    end

endmodule

`default_nettype wire

@@ hw/rtl/spq_ram.sv @@
// Entry memory of the sorted priority ready queue: one write port, one read
// port with registered read data. Depends on spq_pkg for the entry type.
`default_nettype none

module spq_ram #(
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire spq_pkg::t_entry            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output      spq_pkg::t_entry            o_rdata
);

    spq_pkg::t_entry r_mem [DEPTH];
    spq_pkg::t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
